// ===== rtl/flol_pkg.sv =====
// Shared types, constants and helpers of the frequency-ordered lookup list.
// Used by flol_ctrl, flol_datapath and frequency_ordered_lookup_list_top.
// No dependencies.
package flol_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned HITS_W   = 16;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [HITS_W-1:0] HitsMax = {HITS_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 2'd0,
    K_LOCATE = 2'd1,
    K_READ   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_READ,
    S_FIND,
    S_MOVE
  } state_e;

  typedef struct packed {
    logic load;
    logic do_append;
    logic do_read;
    logic do_find;
    logic do_move;
  } ctrl_t;

  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
    logic [IDX_W+POS_W-1:0] w;
    w = {{POS_W{1'b0}}, idx};
    return w[POS_W-1:0];
  endfunction

endpackage

// ===== rtl/frequency_ordered_lookup_list_top.sv =====
// Frequency-ordered lookup list: top level joining controller and datapath.
// Depends on flol_pkg, flol_ctrl, flol_datapath.
// Append and read pass their command state (S_APPEND or S_READ), then strobe done_o
// from the result register; locate first matches over all cells (S_FIND), then reorders (S_MOVE).
// A new command is taken only while busy is low, so commands do not overlap.
// Reset empties the list (fill level zero); results are never stalled.
module frequency_ordered_lookup_list_top
  import flol_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic signed [VALUE_W-1:0]  key_i,
  input  logic [SLOT_W-1:0]          slot_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [POS_W-1:0]           position_o,
  output logic signed [VALUE_W-1:0]  value_o,
  output logic [HITS_W-1:0]          count_o
);

  ctrl_t ctrl;

  flol_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  flol_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .key_i      (key_i),
    .slot_i     (slot_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .position_o (position_o),
    .value_o    (value_o),
    .count_o    (count_o)
  );

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beats on consecutive cycles");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i != K_LOCATE || kind_i == K_LOCATE)
      && (kind_i == K_APPEND || kind_i == K_LOCATE || kind_i == K_READ)) |=> busy)
    else $error("accepted command did not raise busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NOT_FOUND || status_o == ST_FULL))
      |-> (position_o == '0 && value_o == '0 && count_o == '0))
    else $error("not-found or full result carries nonzero payload");

endmodule

// ===== rtl/flol_ctrl.sv =====
// Controller state machine of the lookup list: sequences append, read and locate.
// Depends on flol_pkg.
module flol_ctrl
  import flol_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [KIND_W-1:0]   kind_i,
  output logic                busy,
  output ctrl_t               ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (kind_i)
            K_APPEND: begin
              ctrl_o.load = 1'b1;
              state_d     = S_APPEND;
            end
            K_LOCATE: begin
              ctrl_o.load = 1'b1;
              state_d     = S_FIND;
            end
            K_READ: begin
              ctrl_o.load = 1'b1;
              state_d     = S_READ;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_APPEND: begin
        ctrl_o.do_append = 1'b1;
        state_d          = S_IDLE;
      end
      S_READ: begin
        ctrl_o.do_read = 1'b1;
        state_d        = S_IDLE;
      end
      S_FIND: begin
        ctrl_o.do_find = 1'b1;
        state_d        = S_MOVE;
      end
      S_MOVE: begin
        ctrl_o.do_move = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/flol_datapath.sv =====
// Datapath of the lookup list: entry cells, match and reorder logic, result register.
// Depends on flol_pkg; driven by flol_ctrl commands.
module flol_datapath
  import flol_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic signed [VALUE_W-1:0]  key_i,
  input  logic [SLOT_W-1:0]          slot_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [POS_W-1:0]           position_o,
  output logic signed [VALUE_W-1:0]  value_o,
  output logic [HITS_W-1:0]          count_o
);

  logic signed [VALUE_W-1:0] value_q [DEPTH];
  logic [HITS_W-1:0]         hits_q  [DEPTH];
  logic [CNT_W-1:0]          fill_q;

  logic signed [VALUE_W-1:0] key_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [IDX_W-1:0]          pos_q;
  logic                      found_q;
  logic [HITS_W-1:0]         new_hits_q;

  logic                      res_valid_q;
  logic [STATUS_W-1:0]       res_status_q;
  logic [POS_W-1:0]          res_pos_q;
  logic signed [VALUE_W-1:0] res_value_q;
  logic [HITS_W-1:0]         res_hits_q;

  logic [DEPTH-1:0]          match;
  logic [IDX_W-1:0]          match_idx;
  logic                      match_any;
  logic [DEPTH-1:0]          lower;
  logic [IDX_W-1:0]          target;
  logic [IDX_W+SLOT_W-1:0]   slot_ext;
  logic [IDX_W-1:0]          slot_idx;
  logic                      slot_ok;
  logic [IDX_W-1:0]          rd_idx;
  logic signed [VALUE_W-1:0] rd_value;
  logic [HITS_W-1:0]         rd_hits;
  logic                      full;

  assign full     = (fill_q >= CNT_W'(DEPTH));
  assign slot_ext = {{IDX_W{1'b0}}, slot_q};
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign slot_ok  = ({{CNT_W{1'b0}}, slot_q} < {{SLOT_W{1'b0}}, fill_q});

  always_comb begin
    match     = '0;
    match_idx = '0;
    match_any = 1'b0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      match[j] = (CNT_W'(j) < fill_q) && (value_q[j] == key_q);
      if (match[j]) begin
        match_idx = IDX_W'(j);
        match_any = 1'b1;
      end
    end
  end

  always_comb begin
    lower  = '0;
    target = pos_q;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      lower[j] = (IDX_W'(j) < pos_q) && (hits_q[j] < new_hits_q);
      if (lower[j]) begin
        target = IDX_W'(j);
      end
    end
  end

  assign rd_idx   = ctrl_i.do_read ? slot_idx : match_idx;
  assign rd_value = value_q[rd_idx];
  assign rd_hits  = hits_q[rd_idx];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q  <= key_i;
      slot_q <= slot_i;
    end
    if (ctrl_i.do_find) begin
      pos_q      <= match_idx;
      found_q    <= match_any;
      new_hits_q <= (rd_hits == HitsMax) ? HitsMax : rd_hits + HITS_W'(1);
    end
    for (int j = 0; j < DEPTH; j++) begin
      if (ctrl_i.do_append && !full && (fill_q == CNT_W'(j))) begin
        value_q[j] <= key_q;
        hits_q[j]  <= '0;
      end
      if (ctrl_i.do_move && found_q) begin
        if (IDX_W'(j) == target) begin
          value_q[j] <= key_q;
          hits_q[j]  <= new_hits_q;
        end else if ((IDX_W'(j) > target) && (IDX_W'(j) <= pos_q) && (j > 0)) begin
          value_q[j] <= value_q[(j > 0) ? j - 1 : 0];
          hits_q[j]  <= hits_q[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.do_append && !full) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      res_valid_q <= ctrl_i.do_append | ctrl_i.do_read | ctrl_i.do_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_append) begin
      if (full) begin
        res_status_q <= ST_FULL;
        res_pos_q    <= '0;
        res_value_q  <= '0;
        res_hits_q   <= '0;
      end else begin
        res_status_q <= ST_OK;
        res_pos_q    <= to_pos(fill_q[IDX_W-1:0]);
        res_value_q  <= key_q;
        res_hits_q   <= '0;
      end
    end else if (ctrl_i.do_read) begin
      res_pos_q <= slot_q;
      if (slot_ok) begin
        res_status_q <= ST_OK;
        res_value_q  <= rd_value;
        res_hits_q   <= rd_hits;
      end else begin
        res_status_q <= ST_RANGE;
        res_value_q  <= '0;
        res_hits_q   <= '0;
      end
    end else if (ctrl_i.do_move) begin
      if (found_q) begin
        res_status_q <= ST_OK;
        res_pos_q    <= to_pos(target);
        res_value_q  <= key_q;
        res_hits_q   <= new_hits_q;
      end else begin
        res_status_q <= ST_NOT_FOUND;
        res_pos_q    <= '0;
        res_value_q  <= '0;
        res_hits_q   <= '0;
      end
    end
  end

  assign done_o     = res_valid_q;
  assign status_o   = res_status_q;
  assign position_o = res_pos_q;
  assign value_o    = res_value_q;
  assign count_o    = res_hits_q;

endmodule
